// ===== design/rigid_body_strang_step_core_defines.svh =====
// Assertion helpers shared by the checker
`ifndef RIGID_BODY_STRANG_STEP_CORE_DEFINES_SVH
`define RIGID_BODY_STRANG_STEP_CORE_DEFINES_SVH

// consequent holds in the same cycle
`define RBSS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the next cycle
`define RBSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rbss_pkg.sv =====
package rbss_pkg;

    localparam logic [1:0] OP_ROW  = 2'd0;
    localparam logic [1:0] OP_VEL  = 2'd1;
    localparam logic [1:0] OP_STEP = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] ROW_NONE = 2'd3;

    localparam logic REC_ROW = 1'b0;
    localparam logic REC_VEL = 1'b1;

    localparam logic [2:0] REG_INERTIA_X     = 3'd0;
    localparam logic [2:0] REG_INERTIA_Y     = 3'd1;
    localparam logic [2:0] REG_INERTIA_Z     = 3'd2;
    localparam logic [2:0] REG_INV_INERTIA_X = 3'd3;
    localparam logic [2:0] REG_INV_INERTIA_Y = 3'd4;
    localparam logic [2:0] REG_INV_INERTIA_Z = 3'd5;
    localparam logic [2:0] REG_STEP_SIZE     = 3'd6;
    localparam logic [2:0] REG_SAVE_STRIDE   = 3'd7;

    localparam logic [30:0] INERTIA_RST   = 31'd1048576;
    localparam logic [31:0] STEP_SIZE_RST = 32'd42949673;
    localparam logic [15:0] STRIDE_RST    = 16'd1000;

    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
    localparam logic [42:0] TWO_PI_WIDE = 43'd6746518853;
    // floor(2^52 / 2*pi in Q3.30): quotient estimate from the top angle bits
    localparam logic [19:0] TWO_PI_RECIP = 20'd667544;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518853;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] CORDIC_GAIN = 35'sd652032874;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         row;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic               final_step;
    } item_t;

    typedef struct packed {
        logic [2:0][30:0] inertia;
        logic [2:0][30:0] inv_inertia;
        logic [31:0]      step_size;
        logic [15:0]      save_stride;
    } cfg_t;

    function automatic logic [31:0] atan_q30(input logic [5:0] i);
        logic [31:0] r;
        unique case (i)
            6'd0: r = 32'd843314857;
            6'd1: r = 32'd497837829;
            6'd2: r = 32'd263043837;
            6'd3: r = 32'd133525159;
            6'd4: r = 32'd67021687;
            6'd5: r = 32'd33543516;
            6'd6: r = 32'd16775851;
            6'd7: r = 32'd8388437;
            6'd8: r = 32'd4194283;
            6'd9: r = 32'd2097149;
            6'd10: r = 32'd1048576;
            6'd11: r = 32'd524288;
            6'd12: r = 32'd262144;
            6'd13: r = 32'd131072;
            6'd14: r = 32'd65536;
            6'd15: r = 32'd32768;
            6'd16: r = 32'd16384;
            6'd17: r = 32'd8192;
            6'd18: r = 32'd4096;
            6'd19: r = 32'd2048;
            6'd20: r = 32'd1024;
            6'd21: r = 32'd512;
            6'd22: r = 32'd256;
            6'd23: r = 32'd128;
            6'd24: r = 32'd64;
            6'd25: r = 32'd32;
            6'd26: r = 32'd16;
            6'd27: r = 32'd8;
            6'd28: r = 32'd4;
            6'd29: r = 32'd2;
            6'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/rbss_front.sv =====
module rbss_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [95:0]          s_axis_tdata,  // value_a, value_b, value_c
    input  logic [3:0]           s_axis_tuser,  // opcode, row_select
    input  logic                 s_axis_tlast,
    output logic                 q_valid,
    output rbss_pkg::item_t      q_item,
    input  logic                 q_pop
);

    rbss_pkg::item_t q_mem [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            keep;
    logic            push;
    logic [1:0]      op;
    logic [1:0]      row;

    assign op  = s_axis_tuser[1:0];
    assign row = s_axis_tuser[3:2];

    // unused opcodes and unused rows never reach the back end
    assign keep = (op == rbss_pkg::OP_STEP) || (op == rbss_pkg::OP_VEL) ||
                  ((op == rbss_pkg::OP_ROW) && (row != rbss_pkg::ROW_NONE));

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign q_valid       = (count_reg != 2'd0);
    assign q_item        = q_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{kind: op, row: row,
                                   a: s_axis_tdata[31:0], b: s_axis_tdata[63:32],
                                   c: s_axis_tdata[95:64], final_step: s_axis_tlast};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/rbss_back.sv =====
module rbss_back
#(
    parameter int CORDIC_ITERATIONS = 32,
    parameter int DATA_WIDTH        = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  rbss_pkg::item_t q_item,
    output logic            q_pop,
    input  rbss_pkg::cfg_t  cfg,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [127:0]    m_axis_tdata,  // out_a, out_b, out_c, step_index
    output logic [2:0]      m_axis_tuser,  // record_kind, row_index
    output logic            m_axis_tlast
);

    localparam int SAT_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int ITER     = (CORDIC_ITERATIONS < 40) ? CORDIC_ITERATIONS : 40;
    localparam logic [5:0] ITER_LAST = 6'(ITER - 1);
    localparam logic signed [70:0] SAT_HI = (71'sd1 <<< (SAT_BITS - 1)) - 71'sd1;
    localparam logic signed [70:0] SAT_LO = -SAT_HI - 71'sd1;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_MOM_MUL = 5'd1;
    localparam logic [4:0] S_MOM_WB  = 5'd2;
    localparam logic [4:0] S_VEL_MUL = 5'd3;
    localparam logic [4:0] S_VEL_WB  = 5'd4;
    localparam logic [4:0] S_TH_MUL  = 5'd5;
    localparam logic [4:0] S_TH_WB   = 5'd6;
    localparam logic [4:0] S_MOD     = 5'd7;
    localparam logic [4:0] S_FOLD1   = 5'd8;
    localparam logic [4:0] S_FOLD2   = 5'd9;
    localparam logic [4:0] S_CORDIC  = 5'd10;
    localparam logic [4:0] S_CS      = 5'd11;
    localparam logic [4:0] S_R_LD    = 5'd12;
    localparam logic [4:0] S_R_M1    = 5'd13;
    localparam logic [4:0] S_R_M2    = 5'd14;
    localparam logic [4:0] S_R_M3    = 5'd15;
    localparam logic [4:0] S_R_M4    = 5'd16;
    localparam logic [4:0] S_R_M5    = 5'd17;
    localparam logic [4:0] S_STEP_END = 5'd18;
    localparam logic [4:0] S_OV_MUL  = 5'd19;
    localparam logic [4:0] S_OV_WB   = 5'd20;
    localparam logic [4:0] S_OUT     = 5'd21;
    localparam logic [4:0] S_MOD_Q   = 5'd22;
    localparam logic [4:0] S_MOD_SUB = 5'd23;
    localparam logic [4:0] S_MOD_FIX = 5'd24;

    function automatic logic signed [31:0] sat71(input logic signed [70:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
            r = SAT_HI[31:0];
        else if (v < SAT_LO)
            r = SAT_LO[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [70:0] rnd71(input logic signed [70:0] v,
                                                 input logic [4:0] n);
        return (v + (71'sd1 <<< (n - 5'd1))) >>> n;
    endfunction

    // slots 0..2 momentum, 3..11 orientation rows
    logic signed [31:0] vec_reg [12];
    logic [4:0]         st_reg;
    logic [5:0]         cnt_reg;
    logic [2:0]         sub_reg;
    logic [1:0]         pair_reg;
    rbss_pkg::item_t    item_reg;
    logic [31:0]        step_reg;
    logic [15:0]        stride_reg;
    logic signed [31:0] vel_reg;
    logic signed [69:0] p_reg;
    logic signed [69:0] acc_reg;
    logic [42:0]        mag_reg;
    logic               neg_reg;
    logic signed [34:0] r_reg;
    logic signed [34:0] x_reg;
    logic signed [34:0] y_reg;
    logic               flip_reg;
    logic signed [34:0] c_reg;
    logic signed [34:0] s_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [31:0] res0_reg;
    logic signed [31:0] vo_reg [3];
    logic               o_valid_reg;
    logic               o_kind_reg;
    logic [1:0]         o_row_reg;
    logic signed [31:0] o_a_reg;
    logic signed [31:0] o_b_reg;
    logic signed [31:0] o_c_reg;
    logic [31:0]        o_step_reg;
    logic               o_last_reg;

    logic signed [34:0] mul_a;
    logic signed [34:0] mul_b;
    logic [1:0]         axis;
    logic [1:0]         pp;
    logic [1:0]         qq;
    logic               half;
    logic [3:0]         base;
    logic [3:0]         pidx;
    logic [3:0]         qidx;
    logic [3:0]         oidx;
    logic signed [70:0] p_wide;
    logic signed [70:0] acc_wide;
    logic signed [70:0] ang_wide;
    logic signed [43:0] ang;
    logic signed [34:0] r_fold;
    logic signed [34:0] sh_x;
    logic signed [34:0] sh_y;
    logic signed [34:0] atan_v;
    logic [15:0]        stride_inc;
    logic               out_free;
    logic               out_load;
    logic signed [31:0] item_v;

    always_comb
    begin
        unique case (sub_reg)
            3'd1, 3'd3:
            begin
                axis = 2'd1; pp = 2'd2; qq = 2'd0; half = 1'b1;
            end
            3'd2:
            begin
                axis = 2'd0; pp = 2'd1; qq = 2'd2; half = 1'b0;
            end
            default:
            begin
                axis = 2'd2; pp = 2'd0; qq = 2'd1; half = 1'b1;
            end
        endcase
    end

    assign base = {1'b0, pair_reg, 1'b0} + {2'b00, pair_reg};
    assign pidx = base + {2'b00, pp};
    assign qidx = base + {2'b00, qq};
    assign oidx = 4'd3 + {1'b0, cnt_reg[1:0], 1'b0} + {2'b00, cnt_reg[1:0]};

    assign p_wide   = {p_reg[69], p_reg};
    assign acc_wide = {acc_reg[69], acc_reg};
    assign ang_wide = rnd71(p_wide, half ? 5'd23 : 5'd22);
    assign ang      = ang_wide[43:0];
    assign sh_x     = x_reg >>> cnt_reg;
    assign sh_y     = y_reg >>> cnt_reg;
    assign atan_v   = $signed({3'b000, rbss_pkg::atan_q30(cnt_reg)});
    assign stride_inc = stride_reg + 16'd1;
    assign out_free = !o_valid_reg || m_axis_tready;
    assign out_load = (st_reg == S_OUT) && out_free;

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    item_v = item_reg.a;
            2'd1:    item_v = item_reg.b;
            default: item_v = item_reg.c;
        endcase
    end

    always_comb
    begin
        r_fold = neg_reg ? -$signed({2'b00, mag_reg[32:0]}) : $signed({2'b00, mag_reg[32:0]});
        if (r_fold > rbss_pkg::PI_Q30)
            r_fold = r_fold - rbss_pkg::TWO_PI_Q30;
        else if (r_fold < -rbss_pkg::PI_Q30)
            r_fold = r_fold + rbss_pkg::TWO_PI_Q30;
    end

    // single shared multiplier; operands chosen by the sequencer
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (st_reg)
            S_MOM_MUL:
            begin
                mul_a = {{3{item_v[31]}}, item_v};
                mul_b = {4'b0000, cfg.inertia[cnt_reg[1:0]]};
            end
            S_VEL_MUL:
            begin
                mul_a = {{3{vec_reg[{2'b00, axis}][31]}}, vec_reg[{2'b00, axis}]};
                mul_b = {4'b0000, cfg.inv_inertia[axis]};
            end
            S_OV_MUL:
            begin
                mul_a = {{3{vec_reg[{2'b00, cnt_reg[1:0]}][31]}},
                         vec_reg[{2'b00, cnt_reg[1:0]}]};
                mul_b = {4'b0000, cfg.inv_inertia[cnt_reg[1:0]]};
            end
            S_TH_MUL:
            begin
                mul_a = {{3{vel_reg[31]}}, vel_reg};
                mul_b = {3'b000, cfg.step_size};
            end
            S_MOD:
            begin
                // quotient estimate: top angle bits times the reciprocal of 2*pi
                mul_a = {12'd0, mag_reg[42:20]};
                mul_b = {15'd0, rbss_pkg::TWO_PI_RECIP};
            end
            S_MOD_Q:
            begin
                mul_a = {24'd0, p_reg[42:32]};
                mul_b = rbss_pkg::TWO_PI_Q30;
            end
            S_R_M1:
            begin
                mul_a = c_reg;
                mul_b = {{3{a_reg[31]}}, a_reg};
            end
            S_R_M2:
            begin
                mul_a = s_reg;
                mul_b = {{3{b_reg[31]}}, b_reg};
            end
            S_R_M3:
            begin
                mul_a = c_reg;
                mul_b = {{3{b_reg[31]}}, b_reg};
            end
            S_R_M4:
            begin
                mul_a = s_reg;
                mul_b = {{3{a_reg[31]}}, a_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign q_pop = (st_reg == S_IDLE) && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 12; i++)
            begin
                vec_reg[i] <= (i == 3 || i == 7 || i == 11) ? rbss_pkg::Q30_ONE : 32'sd0;
            end
            for (int i = 0; i < 3; i++)
            begin
                vo_reg[i] <= 32'sd0;
            end
            st_reg      <= S_IDLE;
            cnt_reg     <= '0;
            sub_reg     <= '0;
            pair_reg    <= '0;
            item_reg    <= '0;
            step_reg    <= '0;
            stride_reg  <= '0;
            vel_reg     <= '0;
            p_reg       <= '0;
            acc_reg     <= '0;
            mag_reg     <= '0;
            neg_reg     <= 1'b0;
            r_reg       <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            flip_reg    <= 1'b0;
            c_reg       <= '0;
            s_reg       <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            res0_reg    <= '0;
            o_valid_reg <= 1'b0;
            o_kind_reg  <= 1'b0;
            o_row_reg   <= '0;
            o_a_reg     <= '0;
            o_b_reg     <= '0;
            o_c_reg     <= '0;
            o_step_reg  <= '0;
            o_last_reg  <= 1'b0;
        end
        else
        begin
            p_reg <= mul_a * mul_b;
            if (out_load)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (o_valid_reg && m_axis_tready)
            begin
                o_valid_reg <= 1'b0;
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg <= q_item;
                        cnt_reg  <= '0;
                        sub_reg  <= '0;
                        unique case (q_item.kind)
                            rbss_pkg::OP_VEL:  st_reg <= S_MOM_MUL;
                            rbss_pkg::OP_STEP: st_reg <= S_VEL_MUL;
                            default:
                            begin
                                // row load: slots 3*row+3 onwards
                                vec_reg[4'd3 + {1'b0, q_item.row, 1'b0} + {2'b00, q_item.row}]
                                    <= sat71({{39{q_item.a[31]}}, q_item.a});
                                vec_reg[4'd4 + {1'b0, q_item.row, 1'b0} + {2'b00, q_item.row}]
                                    <= sat71({{39{q_item.b[31]}}, q_item.b});
                                vec_reg[4'd5 + {1'b0, q_item.row, 1'b0} + {2'b00, q_item.row}]
                                    <= sat71({{39{q_item.c[31]}}, q_item.c});
                            end
                        endcase
                    end
                end
                S_MOM_MUL: st_reg <= S_MOM_WB;
                S_MOM_WB:
                begin
                    vec_reg[{2'b00, cnt_reg[1:0]}] <= sat71(rnd71(p_wide, 5'd20));
                    if (cnt_reg == 6'd2)
                    begin
                        step_reg   <= '0;
                        stride_reg <= '0;
                        cnt_reg    <= '0;
                        st_reg     <= S_OV_MUL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                        st_reg  <= S_MOM_MUL;
                    end
                end
                S_VEL_MUL: st_reg <= S_VEL_WB;
                S_VEL_WB:
                begin
                    vel_reg <= sat71(rnd71(p_wide, 5'd20));
                    st_reg  <= S_TH_MUL;
                end
                S_TH_MUL: st_reg <= S_TH_WB;
                S_TH_WB:
                begin
                    neg_reg <= ang[43];
                    mag_reg <= ang[43] ? 43'(-ang) : ang[42:0];
                    st_reg  <= S_MOD;
                end
                S_MOD: st_reg <= S_MOD_Q;
                S_MOD_Q: st_reg <= S_MOD_SUB;
                S_MOD_SUB:
                begin
                    // estimate is low by at most one multiple of 2*pi
                    mag_reg <= mag_reg - p_reg[42:0];
                    st_reg  <= S_MOD_FIX;
                end
                S_MOD_FIX:
                begin
                    if (mag_reg >= rbss_pkg::TWO_PI_WIDE)
                    begin
                        mag_reg <= mag_reg - rbss_pkg::TWO_PI_WIDE;
                    end
                    st_reg <= S_FOLD1;
                end
                S_FOLD1:
                begin
                    r_reg  <= r_fold;
                    st_reg <= S_FOLD2;
                end
                S_FOLD2:
                begin
                    if (r_reg > rbss_pkg::HALF_PI_Q30)
                    begin
                        r_reg    <= r_reg - rbss_pkg::PI_Q30;
                        flip_reg <= 1'b1;
                    end
                    else if (r_reg < -rbss_pkg::HALF_PI_Q30)
                    begin
                        r_reg    <= r_reg + rbss_pkg::PI_Q30;
                        flip_reg <= 1'b1;
                    end
                    else
                    begin
                        flip_reg <= 1'b0;
                    end
                    x_reg   <= rbss_pkg::CORDIC_GAIN;
                    y_reg   <= '0;
                    cnt_reg <= '0;
                    st_reg  <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (!r_reg[34])
                    begin
                        x_reg <= x_reg - sh_y;
                        y_reg <= y_reg + sh_x;
                        r_reg <= r_reg - atan_v;
                    end
                    else
                    begin
                        x_reg <= x_reg + sh_y;
                        y_reg <= y_reg - sh_x;
                        r_reg <= r_reg + atan_v;
                    end
                    if (cnt_reg == ITER_LAST)
                        st_reg <= S_CS;
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_CS:
                begin
                    c_reg    <= flip_reg ? -x_reg : x_reg;
                    s_reg    <= flip_reg ? -y_reg : y_reg;
                    pair_reg <= '0;
                    st_reg   <= S_R_LD;
                end
                S_R_LD:
                begin
                    a_reg  <= vec_reg[pidx];
                    b_reg  <= vec_reg[qidx];
                    st_reg <= S_R_M1;
                end
                S_R_M1: st_reg <= S_R_M2;
                S_R_M2:
                begin
                    acc_reg <= p_reg;
                    st_reg  <= S_R_M3;
                end
                S_R_M3:
                begin
                    res0_reg <= sat71(rnd71(acc_wide + p_wide, 5'd30));
                    st_reg   <= S_R_M4;
                end
                S_R_M4:
                begin
                    acc_reg <= p_reg;
                    st_reg  <= S_R_M5;
                end
                S_R_M5:
                begin
                    vec_reg[pidx] <= res0_reg;
                    vec_reg[qidx] <= sat71(rnd71(acc_wide - p_wide, 5'd30));
                    if (pair_reg != 2'd3)
                    begin
                        pair_reg <= pair_reg + 2'd1;
                        st_reg   <= S_R_LD;
                    end
                    else if (sub_reg != 3'd4)
                    begin
                        sub_reg <= sub_reg + 3'd1;
                        st_reg  <= S_VEL_MUL;
                    end
                    else
                    begin
                        st_reg <= S_STEP_END;
                    end
                end
                S_STEP_END:
                begin
                    step_reg <= step_reg + 32'd1;
                    cnt_reg  <= '0;
                    if (stride_inc >= cfg.save_stride)
                    begin
                        stride_reg <= '0;
                        st_reg     <= S_OV_MUL;
                    end
                    else
                    begin
                        stride_reg <= stride_inc;
                        st_reg     <= item_reg.final_step ? S_OV_MUL : S_IDLE;
                    end
                end
                S_OV_MUL: st_reg <= S_OV_WB;
                S_OV_WB:
                begin
                    vo_reg[cnt_reg[1:0]] <= sat71(rnd71(p_wide, 5'd20));
                    if (cnt_reg == 6'd2)
                    begin
                        cnt_reg <= '0;
                        st_reg  <= S_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                        st_reg  <= S_OV_MUL;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        o_step_reg  <= step_reg;
                        if (cnt_reg == 6'd3)
                        begin
                            o_kind_reg <= rbss_pkg::REC_VEL;
                            o_row_reg  <= 2'd0;
                            o_a_reg    <= vo_reg[0];
                            o_b_reg    <= vo_reg[1];
                            o_c_reg    <= vo_reg[2];
                            o_last_reg <= 1'b1;
                            st_reg     <= S_IDLE;
                        end
                        else
                        begin
                            o_kind_reg <= rbss_pkg::REC_ROW;
                            o_row_reg  <= cnt_reg[1:0];
                            o_a_reg    <= vec_reg[oidx];
                            o_b_reg    <= vec_reg[oidx + 4'd1];
                            o_c_reg    <= vec_reg[oidx + 4'd2];
                            o_last_reg <= 1'b0;
                            cnt_reg    <= cnt_reg + 6'd1;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {o_step_reg, o_c_reg, o_b_reg, o_a_reg};
    assign m_axis_tuser  = {o_row_reg, o_kind_reg};
    assign m_axis_tlast  = o_last_reg;

endmodule

// ===== design/rigid_body_strang_step_core.sv =====
// Row load: written into the orientation slots from idle, after the queue.
// Velocity load: momentum and velocity products, then 4 result transactions.
// Step: 5 sub-rotations, each paced by the one shared multiplier, the
// reciprocal remainder (modulo, quotient, subtract, fix) and the serial
// CORDIC, then a closing step; a record adds velocity products plus 4 transactions.
// rst_n clears state to identity orientation, zero momentum and counters.
module rigid_body_strang_step_core
#(
    parameter int CORDIC_ITERATIONS = 32,
    parameter int DATA_WIDTH        = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [95:0]   s_axis_tdata,  // value_a, value_b, value_c
    input  logic [3:0]    s_axis_tuser,  // opcode, row_select
    input  logic          s_axis_tlast,  // final_step
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,  // out_a, out_b, out_c, step_index
    output logic [2:0]    m_axis_tuser,  // record_kind, row_index
    output logic          m_axis_tlast,  // last_of_record
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    rbss_pkg::cfg_t  cfg_reg;
    rbss_pkg::item_t q_item;
    logic            q_valid;
    logic            q_pop;
    logic            wr_en;
    logic [2:0]      idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inertia     <= {3{rbss_pkg::INERTIA_RST}};
            cfg_reg.inv_inertia <= {3{rbss_pkg::INERTIA_RST}};
            cfg_reg.step_size   <= rbss_pkg::STEP_SIZE_RST;
            cfg_reg.save_stride <= rbss_pkg::STRIDE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                rbss_pkg::REG_INERTIA_X:     cfg_reg.inertia[0]     <= pwdata[30:0];
                rbss_pkg::REG_INERTIA_Y:     cfg_reg.inertia[1]     <= pwdata[30:0];
                rbss_pkg::REG_INERTIA_Z:     cfg_reg.inertia[2]     <= pwdata[30:0];
                rbss_pkg::REG_INV_INERTIA_X: cfg_reg.inv_inertia[0] <= pwdata[30:0];
                rbss_pkg::REG_INV_INERTIA_Y: cfg_reg.inv_inertia[1] <= pwdata[30:0];
                rbss_pkg::REG_INV_INERTIA_Z: cfg_reg.inv_inertia[2] <= pwdata[30:0];
                rbss_pkg::REG_STEP_SIZE:     cfg_reg.step_size      <= pwdata;
                default:                     cfg_reg.save_stride    <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            rbss_pkg::REG_INERTIA_X:     prdata = {1'b0, cfg_reg.inertia[0]};
            rbss_pkg::REG_INERTIA_Y:     prdata = {1'b0, cfg_reg.inertia[1]};
            rbss_pkg::REG_INERTIA_Z:     prdata = {1'b0, cfg_reg.inertia[2]};
            rbss_pkg::REG_INV_INERTIA_X: prdata = {1'b0, cfg_reg.inv_inertia[0]};
            rbss_pkg::REG_INV_INERTIA_Y: prdata = {1'b0, cfg_reg.inv_inertia[1]};
            rbss_pkg::REG_INV_INERTIA_Z: prdata = {1'b0, cfg_reg.inv_inertia[2]};
            rbss_pkg::REG_STEP_SIZE:     prdata = cfg_reg.step_size;
            default:                     prdata = {16'd0, cfg_reg.save_stride};
        endcase
    end

    rbss_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    rbss_back
    #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .DATA_WIDTH        (DATA_WIDTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .cfg           (cfg_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== design/rbss_checker.sv =====
`include "rigid_body_strang_step_core_defines.svh"

module rbss_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    // record closes on the velocity transaction, which carries row zero
    `RBSS_ASSERT_SAME(a_last_is_vel, m_axis_tvalid && m_axis_tlast, (m_axis_tuser[0] == rbss_pkg::REC_VEL) && (m_axis_tuser[2:1] == 2'd0), "record closed by a non-velocity transaction")

    `RBSS_ASSERT_SAME(a_row_valid, m_axis_tvalid && (m_axis_tuser[0] == rbss_pkg::REC_ROW), !m_axis_tlast && (m_axis_tuser[2:1] != rbss_pkg::ROW_NONE), "bad orientation row transaction")

    `RBSS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind rigid_body_strang_step_core rbss_checker u_rbss_checker (.*);

// ===== bench/testbench.sv =====
module testbench;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 600;

    typedef struct {
        logic               kind;
        logic [1:0]         row;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic [31:0]        step;
        logic               last;
    } record_item_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [3:0] s_axis_tuser;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic m_axis_tlast;
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    rigid_body_strang_step_core dut (.*);

    // body state as the block should hold it
    int orient[9];
    int mom[3];
    logic [31:0] step_count;
    logic [15:0] stride_count;
    longint inertia[3];
    longint inv_inertia[3];
    longint step_h;
    logic [15:0] save_stride;

    longint atan_q30_tab[32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0};

    rbss_pkg::item_t pending_items[$];
    record_item_t expected_records[$];
    int errors;
    int cycles;

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return int'(v);
    endfunction

    function automatic longint rnd_shift(longint v, int n);
        return (v + (64'sd1 << (n - 1))) >>> n;
    endfunction

    function automatic int body_velocity(int k);
        return sat32(rnd_shift(longint'(mom[k]) * inv_inertia[k], 20));
    endfunction

    task automatic sin_cos(input longint ang, output longint cs, output longint sn);
        longint r, x, y, nx;
        bit flip;
        r = ang % 64'sd6746518853;
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (r > 64'sd3373259426)
            r -= 64'sd6746518853;
        else if (r < -64'sd3373259426)
            r += 64'sd6746518853;
        if (r > 64'sd1686629713)
        begin
            r -= 64'sd3373259426;
            flip = 1;
        end
        else if (r < -64'sd1686629713)
        begin
            r += 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (r >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                r -= atan_q30_tab[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                r += atan_q30_tab[i];
            end
            x = nx;
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endtask

    task automatic turn_pair(inout int pa, inout int pb, input longint cs, input longint sn);
        longint a, b;
        a = pa;
        b = pb;
        pa = sat32(rnd_shift(cs * a + sn * b, 30));
        pb = sat32(rnd_shift(cs * b - sn * a, 30));
    endtask

    task automatic axis_turn(input int axis, input int p, input int q, input bit half);
        longint cs, sn;
        sin_cos(rnd_shift(longint'(body_velocity(axis)) * step_h, half ? 23 : 22), cs, sn);
        turn_pair(mom[p], mom[q], cs, sn);
        for (int r = 0; r < 3; r++)
            turn_pair(orient[3 * r + p], orient[3 * r + q], cs, sn);
    endtask

    task automatic push_record();
        record_item_t e;
        for (int k = 0; k < 4; k++)
        begin
            e.kind = (k == 3) ? rbss_pkg::REC_VEL : rbss_pkg::REC_ROW;
            e.row = (k < 3) ? k[1:0] : 2'd0;
            e.a = (k < 3) ? orient[3 * k] : body_velocity(0);
            e.b = (k < 3) ? orient[3 * k + 1] : body_velocity(1);
            e.c = (k < 3) ? orient[3 * k + 2] : body_velocity(2);
            e.step = step_count;
            e.last = (k == 3);
            expected_records.push_back(e);
        end
    endtask

    task automatic predict_item(input rbss_pkg::item_t it);
        bit emit;
        case (it.kind)
            rbss_pkg::OP_ROW:
                if (it.row != rbss_pkg::ROW_NONE)
                begin
                    orient[3 * it.row] = it.a;
                    orient[3 * it.row + 1] = it.b;
                    orient[3 * it.row + 2] = it.c;
                end
            rbss_pkg::OP_VEL:
            begin
                mom[0] = sat32(rnd_shift(longint'(it.a) * inertia[0], 20));
                mom[1] = sat32(rnd_shift(longint'(it.b) * inertia[1], 20));
                mom[2] = sat32(rnd_shift(longint'(it.c) * inertia[2], 20));
                step_count = 0;
                stride_count = 0;
                push_record();
            end
            rbss_pkg::OP_STEP:
            begin
                emit = it.final_step;
                axis_turn(2, 0, 1, 1);
                axis_turn(1, 2, 0, 1);
                axis_turn(0, 1, 2, 0);
                axis_turn(1, 2, 0, 1);
                axis_turn(2, 0, 1, 1);
                step_count = step_count + 1;
                stride_count = stride_count + 1;
                if (stride_count >= save_stride)
                begin
                    stride_count = 0;
                    emit = 1;
                end
                if (emit)
                    push_record();
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // driver
    rbss_pkg::item_t cur_item;
    int send_gap;
    bit send_busy;
    bit send_burst;
    bit send_hold;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            s_axis_tlast <= 0;
            send_busy = 0;
            send_gap = 0;
        end
        else
        begin
            if (send_busy && s_axis_tready)
            begin
                predict_item(cur_item);
                send_busy = 0;
                if ($urandom_range(0, 15) == 0)
                    send_burst = ~send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 6);
            end
            if (!send_busy)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_items.size() > 0 && !send_hold)
                begin
                    cur_item = pending_items.pop_front();
                    send_busy = 1;
                end
            end
            s_axis_tvalid <= send_busy;
            s_axis_tdata <= {cur_item.c, cur_item.b, cur_item.a};
            s_axis_tuser <= {cur_item.row, cur_item.kind};
            s_axis_tlast <= cur_item.final_step;
        end
    end

    // monitor
    int recv_gap;
    bit recv_burst;
    record_item_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 0;
            recv_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_records.size() == 0)
                    report("record transaction with nothing expected");
                else
                begin
                    want = expected_records.pop_front();
                    if (m_axis_tuser[0] !== want.kind)
                        report($sformatf("kind %b want %b", m_axis_tuser[0], want.kind));
                    if (m_axis_tuser[2:1] !== want.row)
                        report($sformatf("row %0d want %0d", m_axis_tuser[2:1], want.row));
                    if (m_axis_tdata[31:0] !== want.a)
                        report($sformatf("a %h want %h", m_axis_tdata[31:0], want.a));
                    if (m_axis_tdata[63:32] !== want.b)
                        report($sformatf("b %h want %h", m_axis_tdata[63:32], want.b));
                    if (m_axis_tdata[95:64] !== want.c)
                        report($sformatf("c %h want %h", m_axis_tdata[95:64], want.c));
                    if (m_axis_tdata[127:96] !== want.step)
                        report($sformatf("step %0d want %0d", m_axis_tdata[127:96], want.step));
                    if (m_axis_tlast !== want.last)
                        report($sformatf("last %b want %b", m_axis_tlast, want.last));
                end
                if ($urandom_range(0, 15) == 0)
                    recv_burst = ~recv_burst;
                recv_gap = recv_burst ? 0 : $urandom_range(0, 6);
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 0;
            end
            else
                m_axis_tready <= 1;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            rbss_pkg::REG_INERTIA_X, rbss_pkg::REG_INERTIA_Y, rbss_pkg::REG_INERTIA_Z:
                inertia[idx] = val[30:0];
            rbss_pkg::REG_INV_INERTIA_X, rbss_pkg::REG_INV_INERTIA_Y,
            rbss_pkg::REG_INV_INERTIA_Z:
                inv_inertia[idx - rbss_pkg::REG_INV_INERTIA_X] = val[30:0];
            rbss_pkg::REG_STEP_SIZE:
                step_h = val;
            default:
                save_stride = val[15:0];
        endcase
    endtask

    task automatic add_item(logic [1:0] op, logic [1:0] row, int a, int b, int c, bit fin);
        rbss_pkg::item_t it;
        it.kind = op;
        it.row = row;
        it.a = a;
        it.b = b;
        it.c = c;
        it.final_step = fin;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || send_busy || expected_records.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic int any32();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            default: return int'($urandom);
        endcase
    endfunction

    // velocity in Q12.20 small enough to keep the motion sensible most of the time
    function automatic int some_velocity();
        if ($urandom_range(0, 9) == 0)
            return any32();
        return int'($urandom_range(0, 32'h01ffffff)) - 32'sh00ffffff;
    endfunction

    task automatic random_run(int n_items);
        int done, nsteps;
        done = 0;
        while (done < n_items)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if ($urandom_range(0, 3) == 0)
                    add_item(rbss_pkg::OP_ROW, r[1:0], any32(), any32(), any32(),
                             1'($urandom_range(0, 1)));
                else
                    add_item(rbss_pkg::OP_ROW, r[1:0],
                             int'($urandom_range(0, 32'h7fffffff)) - rbss_pkg::Q30_ONE,
                             int'($urandom_range(0, 32'h7fffffff)) - rbss_pkg::Q30_ONE,
                             int'($urandom_range(0, 32'h7fffffff)) - rbss_pkg::Q30_ONE, 0);
            end
            if ($urandom_range(0, 4) == 0)
                add_item($urandom_range(0, 1) ? rbss_pkg::OP_ROW : rbss_pkg::OP_UNUSED,
                         rbss_pkg::ROW_NONE, any32(), any32(), any32(),
                         1'($urandom_range(0, 1)));
            add_item(rbss_pkg::OP_VEL, 2'($urandom_range(0, 3)), some_velocity(),
                     some_velocity(), some_velocity(), 1'($urandom_range(0, 1)));
            nsteps = $urandom_range(1, 6);
            for (int s = 0; s < nsteps; s++)
                add_item(rbss_pkg::OP_STEP, 2'($urandom_range(0, 3)), any32(), any32(),
                         any32(), (s == nsteps - 1) || ($urandom_range(0, 7) == 0));
            done += nsteps + 4;
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        send_burst = 0;
        recv_burst = 0;
        send_hold = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        cur_item = '0;
        for (int i = 0; i < 9; i++)
            orient[i] = (i % 4 == 0) ? rbss_pkg::Q30_ONE : 0;
        for (int k = 0; k < 3; k++)
        begin
            mom[k] = 0;
            inertia[k] = rbss_pkg::INERTIA_RST;
            inv_inertia[k] = rbss_pkg::INERTIA_RST;
        end
        step_count = 0;
        stride_count = 0;
        step_h = rbss_pkg::STEP_SIZE_RST;
        save_stride = rbss_pkg::STRIDE_RST;
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // steps straight from reset, then loads at the field extremes
        add_item(rbss_pkg::OP_STEP, 2'd0, 0, 0, 0, 1);
        add_item(rbss_pkg::OP_ROW, 2'd0, 32'h7fffffff, 32'h80000000, 0, 1);
        add_item(rbss_pkg::OP_ROW, rbss_pkg::ROW_NONE, -1, -1, -1, 0);
        add_item(rbss_pkg::OP_UNUSED, 2'd2, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1);
        add_item(rbss_pkg::OP_VEL, 2'd3, 32'h7fffffff, 32'h80000000, -1, 1);
        add_item(rbss_pkg::OP_STEP, 2'd3, -1, -1, -1, 0);
        add_item(rbss_pkg::OP_STEP, 2'd1, 0, 0, 0, 1);
        add_item(rbss_pkg::OP_ROW, 2'd1, 0, rbss_pkg::Q30_ONE, 0, 0);
        add_item(rbss_pkg::OP_ROW, 2'd2, 32'h80000000, 0, 32'h7fffffff, 0);
        add_item(rbss_pkg::OP_ROW, 2'd0, rbss_pkg::Q30_ONE, 0, 0, 0);
        add_item(rbss_pkg::OP_VEL, 2'd0, 32'h00100000, -32'sh00200000, 32'h00080000, 0);
        add_item(rbss_pkg::OP_STEP, 2'd0, 0, 0, 0, 0);
        add_item(rbss_pkg::OP_STEP, 2'd0, 0, 0, 0, 1);
        drain();

        // every step emits; largest moments on some axes, largest step
        reg_write(rbss_pkg::REG_INERTIA_X, 32'hffffffff);
        reg_write(rbss_pkg::REG_INERTIA_Y, 32'h7fffffff);
        reg_write(rbss_pkg::REG_INERTIA_Z, 32'h00100000);
        reg_write(rbss_pkg::REG_INV_INERTIA_X, 32'h7fffffff);
        reg_write(rbss_pkg::REG_INV_INERTIA_Y, 32'h00100000);
        reg_write(rbss_pkg::REG_INV_INERTIA_Z, 32'h7fffffff);
        reg_write(rbss_pkg::REG_STEP_SIZE, 32'hffffffff);
        reg_write(rbss_pkg::REG_SAVE_STRIDE, 16'd1);
        random_run(30);

        // smallest values, stride never reached before wrap
        for (int k = 0; k < 6; k++)
            reg_write(k[2:0], 1);
        reg_write(rbss_pkg::REG_STEP_SIZE, 1);
        reg_write(rbss_pkg::REG_SAVE_STRIDE, 16'hffff);
        random_run(25);

        // sender holds off until every record is in, then restarts
        add_item(rbss_pkg::OP_VEL, 2'd0, 32'h00100000, 32'h00100000, 32'h00100000, 0);
        add_item(rbss_pkg::OP_STEP, 2'd0, 0, 0, 0, 1);
        add_item(rbss_pkg::OP_STEP, 2'd0, 0, 0, 0, 1);
        while (pending_items.size() > 1)
            @(posedge clk);
        send_hold = 1;
        while (send_busy || expected_records.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        send_hold = 0;
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                reg_write(k[2:0], $urandom_range(32'h00040000, 32'h00400000));
                reg_write(rbss_pkg::REG_INV_INERTIA_X + k[2:0],
                          $urandom_range(32'h00040000, 32'h00400000));
            end
            reg_write(rbss_pkg::REG_STEP_SIZE, $urandom);
            reg_write(rbss_pkg::REG_SAVE_STRIDE, $urandom_range(1, 4));
            random_run(30);
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && !send_busy && pending_items.size() == 0 && expected_records.size() > 0
            && cycles == CYCLE_LIMIT)
            report("records still outstanding");
endmodule
